// ===== src/trop_pkg.sv =====
// ----------------------------------------------------------------------------
// trop_pkg
// Shared types and constants of the request option parser.
// ----------------------------------------------------------------------------
`default_nettype none
package trop_pkg;

  localparam int NUM_REGS = 8;

  typedef enum logic [2:0] {
    REG_DEF_BLK   = 3'd0,
    REG_DEF_TSIZE = 3'd1,
    REG_DEF_TMO   = 3'd2,
    REG_DEF_WIN   = 3'd3,
    REG_MIN_BLK   = 3'd4,
    REG_MAX_BLK   = 3'd5,
    REG_MIN_WIN   = 3'd6,
    REG_MAX_WIN   = 3'd7
  } reg_idx_t;

  localparam logic [2:0] OPT_NONE  = 3'd0;
  localparam logic [2:0] OPT_BLK   = 3'd1;
  localparam logic [2:0] OPT_TSIZE = 3'd2;
  localparam logic [2:0] OPT_TMO   = 3'd3;
  localparam logic [2:0] OPT_WIN   = 3'd4;

  localparam logic [20:0] MEGABYTE = 21'd1048576;

  // One queue entry: either a filename byte or a finished summary.
  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic [15:0] opcode;
    logic        netascii;
    logic [15:0] blk;
    logic [31:0] tsize;
    logic [31:0] tmo;
    logic [15:0] win;
    logic        any_opt;
  } rec_t;

  typedef struct packed {
    logic [15:0] def_blk;
    logic [31:0] def_tsize;
    logic [31:0] def_tmo;
    logic [15:0] def_win;
    logic [15:0] min_blk;
    logic [15:0] max_blk;
    logic [15:0] min_win;
    logic [15:0] max_win;
  } cfg_t;

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] i);
    logic [79:0] s;
    begin
      unique case (k)
        2'd0: s = {24'h0, "ezisklb"};
        2'd1: s = {40'h0, "ezist"};
        2'd2: s = {24'h0, "tuoemit"};
        default: s = "eziswodniw";
      endcase
      kw_char = (i <= 4'd9) ? s[8 * i +: 8] : 8'd0;
    end
  endfunction

  function automatic logic [4:0] kw_len(input logic [1:0] k);
    unique case (k)
      2'd0: kw_len = 5'd7;
      2'd1: kw_len = 5'd5;
      2'd2: kw_len = 5'd7;
      default: kw_len = 5'd10;
    endcase
  endfunction

  function automatic logic [7:0] mode_char(input logic [2:0] i);
    logic [63:0] s;
    begin
      s = "netascii";
      mode_char = s[63 - 8 * i -: 8];
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/trop_front.sv =====
// ----------------------------------------------------------------------------
// trop_front
// Byte parser: opcode, filename, mode and option pairs into queue entries.
// ----------------------------------------------------------------------------
`default_nettype none
module trop_front import trop_pkg::*; #(
  parameter int MaxStringLen = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire cfg_t       cfg,
  output logic            q_push,
  output rec_t            q_data,
  input  wire logic       q_room
);

  localparam int IW = $clog2(MaxStringLen + 1);

  typedef enum logic [2:0] {
    PH_OPHI, PH_OPLO, PH_FNAME, PH_MODE, PH_NAME, PH_VALUE
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] opcode, opcode_next;
  logic [IW-1:0] sidx, sidx_next;
  logic        mmatch, mmatch_next;
  logic [3:0]  nflags, nflags_next;
  logic [31:0] acc, acc_next;
  logic        stopped, stopped_next;
  logic [15:0] gblk, gblk_next, gwin, gwin_next;
  logic [31:0] gts, gts_next, gtmo, gtmo_next;
  logic        anyo, anyo_next, nasc, nasc_next;

  logic        fire;
  logic [2:0]  sel;
  logic        do_apply;
  logic [31:0] apply_v;
  logic [35:0] prod;
  logic [7:0]  lb;
  logic [IW-1:0] sidx_inc;
  logic [15:0] fblk, fwin;

  assign in_ready = q_room;
  assign fire = in_valid && in_ready;
  assign sidx_inc = (sidx < IW'(MaxStringLen)) ? sidx + 1'b1 : sidx;
  assign lb = (in_byte >= 8'h41 && in_byte <= 8'h5a) ? in_byte + 8'd32 : in_byte;
  assign prod = {4'd0, acc} * 36'd10 + {28'd0, in_byte - 8'h30};

  function automatic logic [31:0] clampv(input logic [31:0] v, input logic [15:0] lo,
                                         input logic [15:0] hi);
    if (v < {16'd0, lo}) clampv = {16'd0, lo};
    else if (v > {16'd0, hi}) clampv = {16'd0, hi};
    else clampv = v;
  endfunction

  always_comb begin
    sel = OPT_NONE;
    for (int k = 3; k >= 0; k--) begin
      if (nflags[k] && {{(32-IW){1'b0}}, sidx} == 32'(kw_len(2'(k)))) sel = 3'(k + 1);
    end
    phase_next = phase; opcode_next = opcode; sidx_next = sidx; mmatch_next = mmatch;
    nflags_next = nflags; acc_next = acc; stopped_next = stopped;
    gblk_next = gblk; gwin_next = gwin; gts_next = gts; gtmo_next = gtmo;
    anyo_next = anyo; nasc_next = nasc;
    do_apply = 1'b0; apply_v = acc;
    q_push = 1'b0;
    q_data = '0;
    if (fire) begin
      unique case (phase)
        PH_OPHI: begin opcode_next = {in_byte, 8'd0}; phase_next = PH_OPLO; end
        PH_OPLO: begin opcode_next = {opcode[15:8], in_byte}; phase_next = PH_FNAME; end
        PH_FNAME: begin
          if (in_byte == 8'd0) begin
            phase_next = PH_MODE; sidx_next = '0; mmatch_next = 1'b1;
          end else begin
            q_push = 1'b1; q_data.name_byte = in_byte;
          end
        end
        PH_MODE: begin
          if (in_byte == 8'd0) begin
            nasc_next = mmatch && sidx == IW'(8);
            phase_next = PH_NAME; sidx_next = '0; nflags_next = 4'hf;
          end else begin
            if (sidx >= IW'(8) || mode_char(sidx[2:0]) != lb) mmatch_next = 1'b0;
            sidx_next = sidx_inc;
            if (in_last) nasc_next = mmatch_next && sidx_inc == IW'(8);
          end
        end
        PH_NAME: begin
          if (in_byte == 8'd0) begin
            phase_next = PH_VALUE; acc_next = '0; stopped_next = 1'b0;
            if (in_last) begin do_apply = 1'b1; apply_v = '0; end
          end else begin
            for (int k = 0; k < 4; k++) begin
              if ({{(32-IW){1'b0}}, sidx} >= 32'(kw_len(2'(k))) ||
                  kw_char(2'(k), sidx[3:0]) != in_byte) nflags_next[k] = 1'b0;
            end
            sidx_next = sidx_inc;
          end
        end
        default: begin
          if (in_byte == 8'd0) begin
            do_apply = 1'b1; phase_next = PH_NAME; sidx_next = '0; nflags_next = 4'hf;
          end else if (!stopped) begin
            if (in_byte >= 8'h30 && in_byte <= 8'h39)
              acc_next = (prod[35:32] != 4'd0) ? 32'hffffffff : prod[31:0];
            else stopped_next = 1'b1;
          end
          if (in_last && in_byte != 8'd0) begin do_apply = 1'b1; apply_v = acc_next; end
        end
      endcase
    end
    // A name cut off by the end of the packet: select from updated match state.
    if (fire && in_last && phase == PH_NAME && in_byte != 8'd0) begin
      sel = OPT_NONE;
      for (int k = 3; k >= 0; k--) begin
        if (nflags_next[k] && {{(32-IW){1'b0}}, sidx_next} == 32'(kw_len(2'(k))))
          sel = 3'(k + 1);
      end
      do_apply = 1'b1; apply_v = '0;
    end
    if (do_apply) begin
      unique case (sel)
        OPT_BLK: begin gblk_next = 16'(clampv(apply_v, cfg.min_blk, cfg.max_blk));
                       anyo_next = 1'b1; end
        OPT_TSIZE: begin gts_next = apply_v; anyo_next = 1'b1; end
        OPT_TMO: begin gtmo_next = apply_v; anyo_next = 1'b1; end
        OPT_WIN: begin gwin_next = 16'(clampv(apply_v, cfg.min_win, cfg.max_win));
                       anyo_next = 1'b1; end
        default: ;
      endcase
    end
    fblk = (gblk_next != 16'd0) ? gblk_next : cfg.def_blk;
    fwin = (gwin_next != 16'd0) ? gwin_next : cfg.def_win;
    if (fire && in_last) begin
      q_push = 1'b1;
      q_data = '0;
      q_data.kind = 1'b1;
      q_data.opcode = opcode_next;
      q_data.netascii = nasc_next;
      q_data.blk = fblk;
      q_data.tsize = (gts_next != 32'd0) ? gts_next : cfg.def_tsize;
      q_data.tmo = (gtmo_next != 32'd0) ? gtmo_next : cfg.def_tmo;
      q_data.win = fwin;
      q_data.any_opt = anyo_next;
    end
  end

  // A filename-phase last byte pushes only the summary from here; the top level
  // adds the byte record beside it, so the queue takes both together, byte first.
  always_ff @(posedge clk) begin
    if (rst || (fire && in_last)) begin
      phase <= PH_OPHI; opcode <= '0; sidx <= '0; mmatch <= 1'b1; nflags <= 4'hf;
      acc <= '0; stopped <= 1'b0; gblk <= '0; gwin <= '0; gts <= '0; gtmo <= '0;
      anyo <= 1'b0; nasc <= 1'b0;
    end else begin
      phase <= phase_next; opcode <= opcode_next; sidx <= sidx_next;
      mmatch <= mmatch_next; nflags <= nflags_next; acc <= acc_next;
      stopped <= stopped_next; gblk <= gblk_next; gwin <= gwin_next; gts <= gts_next;
      gtmo <= gtmo_next; anyo <= anyo_next; nasc <= nasc_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/trop_queue.sv =====
// ----------------------------------------------------------------------------
// trop_queue
// Short register queue between parser and back end; takes up to two
// entries per cycle while it has room, so a filename byte and its summary can land together.
// ----------------------------------------------------------------------------
`default_nettype none
module trop_queue import trop_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_a,
  input  wire rec_t data_a,
  input  wire logic push_b,
  input  wire rec_t data_b,
  output logic      room,
  output logic      nempty,
  output rec_t      head,
  input  wire logic pop
);

  localparam int DEPTH = 4;
  rec_t        mem [DEPTH];
  logic [1:0]  rp, wp;
  logic [2:0]  cnt;
  logic [2:0]  npush;

  assign npush = {2'd0, push_a} + {2'd0, push_b};
  assign room = cnt <= 3'd2;
  assign nempty = cnt != 3'd0;
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (push_a) mem[wp] <= data_a;
    if (push_b) mem[push_a ? wp + 2'd1 : wp] <= data_b;
    if (rst) begin
      rp <= '0; wp <= '0; cnt <= '0;
    end else begin
      wp <= wp + npush[1:0];
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + npush - {2'd0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== src/trop_back.sv =====
// ----------------------------------------------------------------------------
// trop_back
// Output stage: passes filename bytes, computes blocks per megabyte for
// summaries with a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module trop_back import trop_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_nempty,
  input  wire rec_t  q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output rec_t       out_rec,
  output logic [31:0] out_bpm
);

  typedef enum logic [1:0] { S_IDLE, S_DIV, S_OUT } state_t;

  state_t      state;
  logic [4:0]  cnt;
  logic [20:0] quo, rem;
  logic [21:0] trial;

  assign out_valid = state == S_OUT;
  assign q_pop = state == S_IDLE && q_nempty;
  assign trial = {rem, quo[20]} - {6'd0, out_rec.blk};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_nempty) begin
            out_rec <= q_head;
            out_bpm <= 32'hffffffff;
            quo <= MEGABYTE; rem <= '0; cnt <= '0;
            state <= (q_head.kind && q_head.blk != 16'd0) ? S_DIV : S_OUT;
            if (!q_head.kind) out_bpm <= '0;
          end
        end
        S_DIV: begin
          if (!trial[21]) begin
            rem <= trial[20:0]; quo <= {quo[19:0], 1'b1};
          end else begin
            rem <= {rem[19:0], quo[20]}; quo <= {quo[19:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd20) begin
            out_bpm <= {11'd0, !trial[21] ? {quo[19:0], 1'b1} : {quo[19:0], 1'b0}};
            state <= S_OUT;
          end
        end
        default: if (out_ready) state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/tftp_request_option_parser_top.sv =====
// ----------------------------------------------------------------------------
// tftp_request_option_parser_top
// Parses TFTP read/write requests with option extraction.
// ----------------------------------------------------------------------------
// Request bytes enter on the s_axis channel (tdata = byte, tlast = final byte),
// one per cycle while the parser queue has room. Each nonzero filename byte
// yields a record (tuser = 0) and the last byte yields a summary (tuser = 1,
// tlast = 1) on m_axis. A filename record is registered in the queue and then in
// the back-end output register before it leaves. For a summary the back end
// computes 1048576 divided by the block size with a 21-step serial divider
// (all ones for a zero block size); a filename record from the same last byte
// goes first. The back end takes a new record only after the last one has left,
// so long filenames can fill the queue. A stall on m_axis holds the record;
// the four-entry queue then fills and s_axis_tready drops. Reset clears the
// parser and queue and loads register defaults. Registers sit on the APB port
// at byte addresses 4*i.
// ----------------------------------------------------------------------------
`default_nettype none
module tftp_request_option_parser_top import trop_pkg::*; #(
  parameter int MaxStringLen = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // packet_byte
  input  wire logic         s_axis_tlast,   // end_of_packet
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // name_byte[7:0], request_opcode[23:8], transfer_mode[24], block_size[40:25],
  // transfer_size[72:41], timeout_secs[104:73], window_size[120:105],
  // options_present[121], blocks_per_megabyte[153:122]
  output logic [159:0]      m_axis_tdata,
  output logic              m_axis_tuser,   // record_kind
  output logic              m_axis_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  logic wr;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{def_blk: 16'd512, def_tsize: 32'd0, def_tmo: 32'd5, def_win: 16'd1,
               min_blk: 16'd8, max_blk: 16'd65464, min_win: 16'd1, max_win: 16'd65535};
    end else if (wr) begin
      unique case (reg_idx_t'(ridx))
        REG_DEF_BLK:   cfg.def_blk <= pwdata[15:0];
        REG_DEF_TSIZE: cfg.def_tsize <= pwdata;
        REG_DEF_TMO:   cfg.def_tmo <= pwdata;
        REG_DEF_WIN:   cfg.def_win <= pwdata[15:0];
        REG_MIN_BLK:   cfg.min_blk <= pwdata[15:0];
        REG_MAX_BLK:   cfg.max_blk <= pwdata[15:0];
        REG_MIN_WIN:   cfg.min_win <= pwdata[15:0];
        default:       cfg.max_win <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(ridx))
      REG_DEF_BLK:   prdata = {16'd0, cfg.def_blk};
      REG_DEF_TSIZE: prdata = cfg.def_tsize;
      REG_DEF_TMO:   prdata = cfg.def_tmo;
      REG_DEF_WIN:   prdata = {16'd0, cfg.def_win};
      REG_MIN_BLK:   prdata = {16'd0, cfg.min_blk};
      REG_MAX_BLK:   prdata = {16'd0, cfg.max_blk};
      REG_MIN_WIN:   prdata = {16'd0, cfg.min_win};
      default:       prdata = {16'd0, cfg.max_win};
    endcase
  end

  logic f_push, q_room, q_nempty, q_pop;
  rec_t f_data, q_head, o_rec;
  rec_t f_byte, f_sum;
  logic p_byte, p_sum;
  logic [31:0] bpm;
  logic f_name_phase;
  logic [1:0] bcnt;
  logic in_fname;

  trop_front #(.MaxStringLen(MaxStringLen)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_last(s_axis_tlast), .cfg,
    .q_push(f_push), .q_data(f_data), .q_room
  );

  // A last byte inside the filename gives a byte record followed by a summary.
  assign p_byte = f_push && (!f_data.kind ||
                  (s_axis_tlast && s_axis_tdata != 8'd0 && f_name_phase));
  assign p_sum = f_push && f_data.kind;
  always_comb begin
    f_byte = '0;
    f_byte.name_byte = s_axis_tdata;
    f_sum = f_data;
  end

  // Tracks whether the parser is in the filename field, from the stream alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      bcnt <= '0; in_fname <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tlast) begin
        bcnt <= '0; in_fname <= 1'b0;
      end else if (bcnt != 2'd2) begin
        bcnt <= bcnt + 2'd1;
        in_fname <= bcnt == 2'd1;
      end else if (in_fname && s_axis_tdata == 8'd0) begin
        in_fname <= 1'b0;
      end
    end
  end
  assign f_name_phase = in_fname;

  trop_queue u_queue (
    .clk, .rst, .push_a(p_byte), .data_a(f_byte), .push_b(p_sum), .data_b(f_sum),
    .room(q_room), .nempty(q_nempty), .head(q_head), .pop(q_pop)
  );

  trop_back u_back (
    .clk, .rst, .q_nempty, .q_head, .q_pop, .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready), .out_rec(o_rec), .out_bpm(bpm)
  );

  assign m_axis_tuser = o_rec.kind;
  assign m_axis_tlast = o_rec.kind;
  assign m_axis_tdata = {6'd0, bpm, o_rec.any_opt, o_rec.win, o_rec.tmo, o_rec.tsize,
                         o_rec.blk, o_rec.netascii, o_rec.opcode, o_rec.name_byte};

  a_tlast_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser)) else $error("tlast mismatch");
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[159:8] == '0))
    else $error("byte record carries summary fields");
  a_sum_name: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("summary carries a name byte");

endmodule
`default_nettype wire
